@@ hw/rtl/lpse_pkg.sv @@
// ----------------------------------------------------------------------------
// lpse_pkg - shared types and constants of the LED pixel SPI encoder
// Register indexes, symbol codes and the byte-to-symbol expansion.
// ----------------------------------------------------------------------------
package lpse_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned COORD_W     = 6;
    localparam int unsigned DIM_W       = 7;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned INDEX_W     = 12;
    localparam int unsigned SYM_W       = 3;
    localparam int unsigned PATTERN_W   = BYTE_W * SYM_W;
    localparam int unsigned PRODUCT_W   = 2 * BYTE_W;

    localparam int unsigned S_TDATA_W   = 40;
    localparam int unsigned M_TDATA_W   = 88;

    localparam logic [SYM_W-1:0]     SYM_ONE    = 3'b110;
    localparam logic [SYM_W-1:0]     SYM_ZERO   = 3'b100;
    localparam logic [PRODUCT_W-1:0] ROUND_HALF = 16'd128;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BRIGHTNESS    = 3'd0,
        REG_PANEL_WIDTH   = 3'd1,
        REG_PANEL_HEIGHT  = 3'd2,
        REG_ROWS_DOWN     = 3'd3,
        REG_LEFT_FIRST    = 3'd4,
        REG_SERPENTINE    = 3'd5
    } t_cfg_reg;

    // Expand a byte MSB first: a one becomes 110, a zero becomes 100.
    function automatic logic [PATTERN_W-1:0] expand_byte(input logic [BYTE_W-1:0] v);
        logic [PATTERN_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < BYTE_W; k++) begin
            acc[k*SYM_W +: SYM_W] = v[k] ? SYM_ONE : SYM_ZERO;
        end
        return acc;
    endfunction

endpackage

@@ hw/rtl/led_pixel_spi_encoder.sv @@
// ----------------------------------------------------------------------------
// led_pixel_spi_encoder - pixel to LED strip SPI symbol encoder
// Scales each colour byte by the brightness register with rounding, expands
// it into 3-bit SPI symbols and maps the panel position to a strip index.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Transfer when                 Carries
//  s_axis    in         tvalid & tready               one pixel
//  m_axis    out        tvalid & tready               strip index, flag, patterns
//  cfg       in         i_cfg_valid & o_cfg_ready     register index and value
//
// One pixel enters per cycle while the output is not stalled; the three register
// stages (multiply, index/scale, expand) each hold one pixel with its own valid
// bit. A stage advances when it is empty or the stage after it advances, so a
// stalled output holds only the stages that are full and bubbles still fill.
// Reset (i_rst_n low at a clock edge) empties the pipeline and loads the
// register defaults. Configuration writes are always taken: o_cfg_ready is tied high.
//
module led_pixel_spi_encoder #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [5:0] column, [11:6] row, [19:12] green_in, [27:20] red_in,
    // [35:28] blue_in, [39:36] zero
    input  logic [lpse_pkg::S_TDATA_W-1:0]       i_s_axis_tdata,

    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // [11:0] strip_index, [12] coord_valid, [36:13] green_bits,
    // [60:37] red_bits, [84:61] blue_bits, [87:85] zero
    output logic [lpse_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,

    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lpse_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [lpse_pkg::BYTE_W-1:0]          i_cfg_data
);

    localparam int unsigned COORD_W   = lpse_pkg::COORD_W;
    localparam int unsigned DIM_W     = lpse_pkg::DIM_W;
    localparam int unsigned BYTE_W    = lpse_pkg::BYTE_W;
    localparam int unsigned PRODUCT_W = lpse_pkg::PRODUCT_W;
    localparam int unsigned PATTERN_W = lpse_pkg::PATTERN_W;
    localparam int unsigned INDEX_W   = lpse_pkg::INDEX_W;
    // ry * w + rx fits in 7 + 7 bits
    localparam int unsigned SUM_W     = DIM_W + DIM_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] r_brightness;
    logic [DIM_W-1:0]  r_panel_width;
    logic [DIM_W-1:0]  r_panel_height;
    logic              r_rows_down;
    logic              r_left_first;
    logic              r_serpentine;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness    <= 8'd16;
            r_panel_width   <= 7'd16;
            r_panel_height  <= 7'd16;
            r_rows_down     <= 1'b1;
            r_left_first    <= 1'b1;
            r_serpentine    <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (lpse_pkg::t_cfg_reg'(i_cfg_index))
                lpse_pkg::REG_BRIGHTNESS:    r_brightness    <= i_cfg_data;
                lpse_pkg::REG_PANEL_WIDTH:   r_panel_width   <= i_cfg_data[DIM_W-1:0];
                lpse_pkg::REG_PANEL_HEIGHT:  r_panel_height  <= i_cfg_data[DIM_W-1:0];
                lpse_pkg::REG_ROWS_DOWN:     r_rows_down     <= i_cfg_data[0];
                lpse_pkg::REG_LEFT_FIRST:    r_left_first    <= i_cfg_data[0];
                lpse_pkg::REG_SERPENTINE:    r_serpentine    <= i_cfg_data[0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // Effective panel size: clamp to the maximum the design supports.
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;

    always_comb begin
        if (int'(r_panel_width) > MAX_WIDTH) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = r_panel_width;
        end
        if (int'(r_panel_height) > MAX_HEIGHT) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_panel_height;
        end
    end

    // ------------------------------------------------------------------
    // Stage valid bits and flow control
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3;

    // A stage loads when it is empty or its content moves on this cycle.
    assign adv3 = !r_v3 || i_m_axis_tready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign o_s_axis_tready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_s_axis_tvalid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: colour products, coordinate check, row mapping
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] in_column;
    logic [COORD_W-1:0] in_row;
    logic [BYTE_W-1:0]  in_green;
    logic [BYTE_W-1:0]  in_red;
    logic [BYTE_W-1:0]  in_blue;

    assign in_column = i_s_axis_tdata[5:0];
    assign in_row    = i_s_axis_tdata[11:6];
    assign in_green  = i_s_axis_tdata[19:12];
    assign in_red    = i_s_axis_tdata[27:20];
    assign in_blue   = i_s_axis_tdata[35:28];

    logic [DIM_W-1:0]   n_ry_full;
    logic               n_forward;
    logic               n_coord_ok;

    always_comb begin
        n_coord_ok = ({1'b0, in_column} < w_eff) && ({1'b0, in_row} < h_eff);
        // flip rows when the panel is wired bottom to top
        if (r_rows_down) begin
            n_ry_full = {1'b0, in_row};
        end else begin
            n_ry_full = h_eff - 7'd1 - {1'b0, in_row};
        end
        if (r_serpentine) begin
            n_forward = r_left_first ? !n_ry_full[0] : n_ry_full[0];
        end else begin
            n_forward = r_left_first;
        end
    end

    logic [PRODUCT_W-1:0] r1_green_p, r1_red_p, r1_blue_p;
    logic [COORD_W-1:0]   r1_column;
    logic [DIM_W-1:0]     r1_ry;
    logic                 r1_forward;
    logic                 r1_coord_ok;

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            // rounded product, v * b + 128, never exceeds 16 bits
            r1_green_p  <= PRODUCT_W'(in_green * r_brightness) + lpse_pkg::ROUND_HALF;
            r1_red_p    <= PRODUCT_W'(in_red * r_brightness) + lpse_pkg::ROUND_HALF;
            r1_blue_p   <= PRODUCT_W'(in_blue * r_brightness) + lpse_pkg::ROUND_HALF;
            r1_column   <= in_column;
            r1_ry       <= n_ry_full;
            r1_forward  <= n_forward;
            r1_coord_ok <= n_coord_ok;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: strip index ry * w + rx, take the scaled bytes
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] n_rx;
    logic [SUM_W-1:0] n_index_sum;

    always_comb begin
        if (r1_forward) begin
            n_rx = {1'b0, r1_column};
        end else begin
            n_rx = w_eff - 7'd1 - {1'b0, r1_column};
        end
        n_index_sum = SUM_W'(r1_ry * w_eff) + SUM_W'(n_rx);
    end

    logic [BYTE_W-1:0]  r2_green_s, r2_red_s, r2_blue_s;
    logic [INDEX_W-1:0] r2_index;
    logic               r2_coord_ok;

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r2_green_s  <= r1_green_p[PRODUCT_W-1:BYTE_W];
            r2_red_s    <= r1_red_p[PRODUCT_W-1:BYTE_W];
            r2_blue_s   <= r1_blue_p[PRODUCT_W-1:BYTE_W];
            // outside the panel the index reads as zero
            r2_index    <= r1_coord_ok ? n_index_sum[INDEX_W-1:0] : '0;
            r2_coord_ok <= r1_coord_ok;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: symbol expansion into the output register
    // ------------------------------------------------------------------
    logic [PATTERN_W-1:0] r3_green_bits, r3_red_bits, r3_blue_bits;
    logic [INDEX_W-1:0]   r3_index;
    logic                 r3_coord_ok;

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r3_green_bits <= lpse_pkg::expand_byte(r2_green_s);
            r3_red_bits   <= lpse_pkg::expand_byte(r2_red_s);
            r3_blue_bits  <= lpse_pkg::expand_byte(r2_blue_s);
            r3_index      <= r2_index;
            r3_coord_ok   <= r2_coord_ok;
        end
    end

    assign o_m_axis_tvalid = r_v3;

    assign o_m_axis_tdata = {3'b000, r3_blue_bits, r3_red_bits, r3_green_bits,
                             r3_coord_ok, r3_index};

endmodule

@@ tb/led_pixel_spi_encoder_test.sv @@
// ----------------------------------------------------------------------------
// led_pixel_spi_encoder_test - self-checking bench for the LED pixel encoder
// Streams pixels through the encoder under several panel and brightness
// settings, predicts every strip index, flag and symbol pattern, and checks
// each output transfer in order while both sides idle in random bursts until the closing stretch.
// ----------------------------------------------------------------------------
module led_pixel_spi_encoder_test;

    localparam int unsigned CFG_INDEX_W = lpse_pkg::CFG_INDEX_W;
    localparam int unsigned COORD_W     = lpse_pkg::COORD_W;
    localparam int unsigned DIM_W       = lpse_pkg::DIM_W;
    localparam int unsigned BYTE_W      = lpse_pkg::BYTE_W;
    localparam int unsigned INDEX_W     = lpse_pkg::INDEX_W;
    localparam int unsigned SYM_W       = lpse_pkg::SYM_W;
    localparam int unsigned PATTERN_W   = lpse_pkg::PATTERN_W;
    localparam int unsigned PRODUCT_W   = lpse_pkg::PRODUCT_W;
    localparam int unsigned S_TDATA_W   = lpse_pkg::S_TDATA_W;
    localparam int unsigned M_TDATA_W   = lpse_pkg::M_TDATA_W;

    localparam int          PANEL_MAX_W   = 64;
    localparam int          PANEL_MAX_H   = 64;
    localparam int          PIPE_DEPTH    = 3;
    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          RANDOM_PHASES = 8;
    localparam int          PHASE_PIXELS  = 125;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    // One pixel as it travels in s_axis tdata, column in the lowest bits.
    typedef struct packed {
        logic [BYTE_W-1:0]  blue;
        logic [BYTE_W-1:0]  red;
        logic [BYTE_W-1:0]  green;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] column;
    } t_pixel;

    // One encoded pixel as it travels in m_axis tdata, strip index lowest.
    typedef struct packed {
        logic [PATTERN_W-1:0] blue_bits;
        logic [PATTERN_W-1:0] red_bits;
        logic [PATTERN_W-1:0] green_bits;
        logic                 coord_valid;
        logic [INDEX_W-1:0]   strip_index;
    } t_led_word;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow registers, encoder prediction, in-order compare
    // ------------------------------------------------------------------------
    class t_led_scoreboard;
        logic [BYTE_W-1:0] brightness;
        logic [DIM_W-1:0]  panel_width;
        logic [DIM_W-1:0]  panel_height;
        logic              rows_down;
        logic              left_first;
        logic              serpentine;
        t_led_word         led_words_q[$];
        int                errors;

        function new();
            brightness    = 8'd16;
            panel_width   = 7'd16;
            panel_height  = 7'd16;
            rows_down     = 1'b1;
            left_first    = 1'b1;
            serpentine    = 1'b1;
            errors        = 0;
        endfunction

        function int unsigned width_eff();
            return (panel_width > PANEL_MAX_W) ? PANEL_MAX_W : panel_width;
        endfunction

        function int unsigned height_eff();
            return (panel_height > PANEL_MAX_H) ? PANEL_MAX_H : panel_height;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [BYTE_W-1:0] data);
            case (lpse_pkg::t_cfg_reg'(idx))
                lpse_pkg::REG_BRIGHTNESS:   brightness   = data;
                lpse_pkg::REG_PANEL_WIDTH:  panel_width  = data[DIM_W-1:0];
                lpse_pkg::REG_PANEL_HEIGHT: panel_height = data[DIM_W-1:0];
                lpse_pkg::REG_ROWS_DOWN:    rows_down    = data[0];
                lpse_pkg::REG_LEFT_FIRST:   left_first   = data[0];
                lpse_pkg::REG_SERPENTINE:   serpentine   = data[0];
                default: ;
            endcase
        endfunction

        // Brightness scale with rounding to nearest.
        function logic [BYTE_W-1:0] dim_byte(logic [BYTE_W-1:0] v);
            logic [PRODUCT_W-1:0] prod;
            prod = PRODUCT_W'(v) * PRODUCT_W'(brightness) + PRODUCT_W'(128);
            return prod[PRODUCT_W-1:BYTE_W];
        endfunction

        // Shift in one symbol per bit, MSB first, so bit 7 lands on top.
        function logic [PATTERN_W-1:0] to_symbols(logic [BYTE_W-1:0] v);
            logic [PATTERN_W-1:0] acc;
            acc = '0;
            for (int k = BYTE_W - 1; k >= 0; k--) begin
                acc = {acc[PATTERN_W-SYM_W-1:0],
                       (v[k] ? lpse_pkg::SYM_ONE : lpse_pkg::SYM_ZERO)};
            end
            return acc;
        endfunction

        function t_led_word encode(t_pixel p);
            t_led_word   res;
            int unsigned w;
            int unsigned h;
            int unsigned ry;
            int unsigned rx;
            logic        forward;
            logic        on_panel;
            w        = width_eff();
            h        = height_eff();
            on_panel = (p.column < w) && (p.row < h);
            res.strip_index = '0;
            if (on_panel) begin
                ry = rows_down ? p.row : (h - 1 - p.row);
                if (serpentine) begin
                    forward = left_first ? (ry[0] == 1'b0) : (ry[0] == 1'b1);
                end else begin
                    forward = left_first;
                end
                rx = forward ? p.column : (w - 1 - p.column);
                res.strip_index = INDEX_W'(ry * w + rx);
            end
            res.coord_valid = on_panel;
            res.green_bits  = to_symbols(dim_byte(p.green));
            res.red_bits    = to_symbols(dim_byte(p.red));
            res.blue_bits   = to_symbols(dim_byte(p.blue));
            return res;
        endfunction

        function void note_pixel(t_pixel p);
            led_words_q.push_back(encode(p));
        endfunction

        function void compare_field(string field, logic [PATTERN_W-1:0] exp_val,
                                    logic [PATTERN_W-1:0] act_val);
            if (exp_val !== act_val) begin
                errors++;
                $display("%0t: %s mismatch, expected %h actual %h",
                         $time, field, exp_val, act_val);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata);
            t_led_word got;
            t_led_word want;
            got = tdata[$bits(t_led_word)-1:0];
            if (led_words_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected output transfer, expected none actual %h",
                         $time, tdata);
                return;
            end
            want = led_words_q.pop_front();
            compare_field("strip_index", PATTERN_W'(want.strip_index),
                          PATTERN_W'(got.strip_index));
            compare_field("coord_valid", PATTERN_W'(want.coord_valid),
                          PATTERN_W'(got.coord_valid));
            compare_field("green_bits", want.green_bits, got.green_bits);
            compare_field("red_bits",   want.red_bits,   got.red_bits);
            compare_field("blue_bits",  want.blue_bits,  got.blue_bits);
        endfunction

        function int pending();
            return led_words_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_s_axis_tvalid;
    logic                    o_s_axis_tready;
    logic [S_TDATA_W-1:0]    i_s_axis_tdata;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready;
    logic [M_TDATA_W-1:0]    o_m_axis_tdata;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_INDEX_W-1:0]  i_cfg_index;
    logic [BYTE_W-1:0]       i_cfg_data;

    led_pixel_spi_encoder #(
        .MAX_WIDTH  (PANEL_MAX_W),
        .MAX_HEIGHT (PANEL_MAX_H)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    t_led_scoreboard sb;
    logic            quiet_run;     // set for the closing stretch: no idling at all
    int              cycle_count;

    // Clock: 12 units per period.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Watchdog: end the run if the stream ever wedges.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Check every output transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_result(o_m_axis_tdata);
        end
    end

    // Downstream backpressure: random stall bursts between ready
    // stretches; hold ready high once the quiet stretch begins.
    initial begin
        int   run_len;
        logic ready_val;
        i_m_axis_tready = 1'b0;
        forever begin
            if (quiet_run || $urandom_range(0, 2) == 0) begin
                ready_val = 1'b1;
                run_len   = $urandom_range(1, 30);
            end else if (i_m_axis_tready) begin
                ready_val = 1'b0;
                run_len   = $urandom_range(1, 17);
            end else begin
                ready_val = 1'b1;
                run_len   = $urandom_range(1, 6);
            end
            repeat (run_len) begin
                @(negedge i_clk);
                i_m_axis_tready = quiet_run ? 1'b1 : ready_val;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Register write over the config channel; only called while idle.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [BYTE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_panel(logic [7:0] bright, logic [7:0] width, logic [7:0] height,
                             logic [7:0] t2b, logic [7:0] left, logic [7:0] serp);
        write_reg(lpse_pkg::REG_BRIGHTNESS,   bright);
        write_reg(lpse_pkg::REG_PANEL_WIDTH,  width);
        write_reg(lpse_pkg::REG_PANEL_HEIGHT, height);
        write_reg(lpse_pkg::REG_ROWS_DOWN,    t2b);
        write_reg(lpse_pkg::REG_LEFT_FIRST,   left);
        write_reg(lpse_pkg::REG_SERPENTINE,   serp);
    endtask

    // Push one pixel; keep tvalid high into the next call unless a gap is
    // drawn, so back-to-back transfers never drop valid in between.
    task automatic send_pixel(logic [5:0] col, logic [5:0] row,
                              logic [7:0] g, logic [7:0] r, logic [7:0] b);
        t_pixel p;
        int     gap;
        p = '{blue: b, red: r, green: g, row: row, column: col};
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {{(S_TDATA_W - $bits(t_pixel)){1'b0}}, p};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_pixel(p);
        gap = 0;
        if (!quiet_run && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 17);
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drop valid, wait for every predicted word, then let the pipe empty.
    task automatic drain_pipe();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    // Random colour byte with the extremes drawn now and then.
    function automatic logic [7:0] random_colour();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Random pixel stream: mostly on-panel coordinates, some anywhere.
    task automatic run_random(int count);
        int unsigned w;
        int unsigned h;
        logic [5:0]  col;
        logic [5:0]  row;
        w = sb.width_eff();
        h = sb.height_eff();
        for (int n = 0; n < count; n++) begin
            if (w > 0 && h > 0 && $urandom_range(0, 4) != 0) begin
                col = 6'($urandom_range(0, w - 1));
                row = 6'($urandom_range(0, h - 1));
            end else begin
                col = 6'($urandom);
                row = 6'($urandom);
            end
            send_pixel(col, row, random_colour(), random_colour(), random_colour());
            // Hold off now and then until the whole stream has come back.
            if (!quiet_run && $urandom_range(0, 199) == 0) drain_pipe();
        end
    endtask

    // Random register setting, with empty and oversized panels mixed in.
    task automatic random_panel();
        logic [7:0] width;
        logic [7:0] height;
        case ($urandom_range(0, 9))
            0:       width = 8'd0;
            1:       width = 8'($urandom_range(65, 255));
            2:       width = 8'd64;
            default: width = 8'($urandom_range(1, 64));
        endcase
        case ($urandom_range(0, 9))
            0:       height = 8'd0;
            1:       height = 8'($urandom_range(65, 255));
            2:       height = 8'd64;
            default: height = 8'($urandom_range(1, 64));
        endcase
        set_panel(8'($urandom), width, height, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb              = new();
        quiet_run       = 1'b0;
        cycle_count     = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset defaults: 16x16 serpentine, starting top left, brightness 16.
        send_pixel(6'd0,  6'd0,  8'h00, 8'h00, 8'h00);
        send_pixel(6'd15, 6'd0,  8'hFF, 8'hFF, 8'hFF);
        send_pixel(6'd15, 6'd1,  8'h80, 8'h01, 8'h7F);   // odd row runs backward
        send_pixel(6'd0,  6'd15, 8'hAA, 8'h55, 8'h0F);
        send_pixel(6'd16, 6'd0,  8'h10, 8'h20, 8'h30);   // column just past the edge
        send_pixel(6'd0,  6'd16, 8'h40, 8'h50, 8'h60);   // row just past the edge
        send_pixel(6'd63, 6'd63, 8'hFF, 8'h00, 8'hFF);
        send_pixel(6'd42, 6'd21, 8'h55, 8'hAA, 8'hF0);
        drain_pipe();

        // Largest panel, full brightness, flipped rows, right start, straight.
        set_panel(8'hFF, 8'd64, 8'd64, 8'd0, 8'd0, 8'd0);
        send_pixel(6'd0,  6'd0,  8'hFF, 8'hFE, 8'h01);
        send_pixel(6'd63, 6'd63, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(6'd63, 6'd0,  8'h7F, 8'h80, 8'h81);
        send_pixel(6'd0,  6'd63, 8'h00, 8'h01, 8'h02);
        send_pixel(6'd21, 6'd42, 8'hC3, 8'h3C, 8'h99);
        drain_pipe();

        // Single-pixel panel, brightness zero, serpentine from the right.
        set_panel(8'h00, 8'd1, 8'd1, 8'd1, 8'd0, 8'd1);
        send_pixel(6'd0, 6'd0, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(6'd1, 6'd0, 8'hFF, 8'h80, 8'h01);
        send_pixel(6'd0, 6'd1, 8'h80, 8'hFF, 8'h7F);
        drain_pipe();

        // Oversized sizes clamp to the maximum; writes past the last register
        // must change nothing.
        set_panel(8'h80, 8'hFF, 8'hC1, 8'hFE, 8'hFF, 8'h01);
        write_reg(REG_SPARE_LO, 8'h00);
        write_reg(REG_SPARE_HI, 8'hFF);
        send_pixel(6'd63, 6'd63, 8'hFF, 8'h7F, 8'h80);
        send_pixel(6'd32, 6'd17, 8'h01, 8'h02, 8'hFE);
        drain_pipe();

        // Empty panel: every coordinate is off the panel.
        set_panel(8'h01, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0);
        send_pixel(6'd0, 6'd0, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(6'd5, 6'd5, 8'h80, 8'h81, 8'h7F);
        drain_pipe();

        // Random settings, random pixels; a full-range panel ends the run
        // without any idling on either side.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == RANDOM_PHASES - 1) begin
                set_panel(8'($urandom), 8'd64, 8'd64, 8'($urandom), 8'($urandom),
                          8'($urandom));
                quiet_run = 1'b1;
            end else begin
                random_panel();
            end
            run_random(PHASE_PIXELS);
            if (ph == 0) begin
                // Pause the stream until every result is back.
                drain_pipe();
                run_random(8);
            end
            drain_pipe();
        end

        repeat (2 * PIPE_DEPTH) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
